[hdl/mme_pkg.sv]
package mme_pkg;

  localparam int MAX_DIM      = 8;
  localparam int ELEM_WIDTH   = 16;

  localparam int CMD_W        = 2;
  localparam int IDX_FIELD_W  = 3;
  localparam int ELEM_FIELD_W = 16;
  localparam int SUM_W        = 35;
  localparam int DIM_REG_W    = 4;
  localparam int CFG_IDX_W    = 2;

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
  localparam int CMP_W  = (ACC_W > SUM_W) ? ACC_W : SUM_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [CMP_W-1:0] SUM_MAX_C =
    {{(CMP_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
  localparam logic signed [CMP_W-1:0] SUM_MIN_C = ~SUM_MAX_C;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_START  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] out_row;
    logic [IDX_FIELD_W-1:0] out_col;
    logic signed [SUM_W-1:0] product_sum;
    logic                    last;
  } result_t;

  // Control that travels alongside each multiply-accumulate step.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             last_k;
    logic             last_elem;
  } tag_t;

  // Index of the last step for a dimension register: zero acts as one,
  // anything above MAX_DIM acts as MAX_DIM.
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_REG_W-1:0] r);
    logic [DIM_REG_W-1:0] d;
    d = r;
    if (d == '0) d = DIM_REG_W'(1);
    if (int'(d) > MAX_DIM) d = DIM_REG_W'(MAX_DIM);
    return IDX_W'(d - DIM_REG_W'(1));
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
    logic signed [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w > SUM_MAX_C) w = SUM_MAX_C;
    if (w < SUM_MIN_C) w = SUM_MIN_C;
    return SUM_W'(w);
  endfunction

endpackage

[hdl/mme_cmd_if.sv]
interface mme_cmd_if import mme_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic [CMD_W-1:0]               command;
  logic [IDX_FIELD_W-1:0]         row_index;
  logic [IDX_FIELD_W-1:0]         col_index;
  logic signed [ELEM_FIELD_W-1:0] element;

  modport source (output valid, command, row_index, col_index, element, input ready);
  modport sink (input valid, command, row_index, col_index, element, output ready);
endinterface

[hdl/mme_res_if.sv]
interface mme_res_if import mme_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_FIELD_W-1:0]  out_row;
  logic [IDX_FIELD_W-1:0]  out_col;
  logic signed [SUM_W-1:0] product_sum;
  logic                    last;

  modport source (output valid, out_row, out_col, product_sum, last, input ready);
  modport sink (input valid, out_row, out_col, product_sum, last, output ready);
endinterface

[hdl/mme_cfg_if.sv]
interface mme_cfg_if import mme_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_REG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/matrix_multiply_engine.sv]
// Matrix multiply engine, C = A * B, with A and B held in two synchronous
// element memories of MAX_DIM*MAX_DIM entries, each with one write and one
// read port. A load command writes its element when it is accepted. A start
// command holds off the command channel while the sequencer walks i, j, k
// and issues one multiply-accumulate per cycle, while queue slots allow, from
// the two memory read ports; a step passes the memory read, product and
// accumulator registers before its result enters a four-entry output queue.
// The sequencer only opens a new dot product when a queue slot is reserved
// for it, so a slow consumer stretches the run. Memory contents are not
// cleared by reset: every element a start reads must have been loaded first.
module matrix_multiply_engine import mme_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mme_cmd_if.sink    cmd_ch,
  mme_cfg_if.sink    cfg_ch,
  mme_res_if.source  res_ch
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state;

  logic [DIM_REG_W-1:0] rows_a;
  logic [DIM_REG_W-1:0] inner_dim;
  logic [DIM_REG_W-1:0] cols_b;

  logic [IDX_W-1:0] i_cnt, j_cnt, k_cnt;
  logic [IDX_W-1:0] i_last, j_last, k_last;

  logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_b [DEPTH];
  logic signed [ELEM_WIDTH-1:0] a_rd, b_rd;

  logic                cmd_beat;
  logic                load_ok;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b;

  logic                issue;
  logic                issue_last;
  tag_t                tag0;
  logic                v1, v2, push3;
  tag_t                tag1, tag2, tag3;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic [FIFO_CNT_W-1:0] credits;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  result_t               fifo_mem [FIFO_DEPTH];
  result_t               head;
  logic                  pop;

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_REG_W'(8);
      inner_dim <= DIM_REG_W'(8);
      cols_b    <= DIM_REG_W'(8);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ROWS_A:    rows_a    <= cfg_ch.data;
        REG_INNER_DIM: inner_dim <= cfg_ch.data;
        REG_COLS_B:    cols_b    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign i_last = dim_last(rows_a);
  assign j_last = dim_last(cols_b);
  assign k_last = dim_last(inner_dim);

  // --------------------------------------------------------------- command
  assign cmd_ch.ready = (state == S_IDLE);
  assign cmd_beat     = cmd_ch.valid && cmd_ch.ready;
  assign load_ok      = cmd_beat && (int'(cmd_ch.row_index) < MAX_DIM)
                        && (int'(cmd_ch.col_index) < MAX_DIM);
  assign wr_addr      = ADDR_W'(int'(cmd_ch.row_index) * MAX_DIM + int'(cmd_ch.col_index));
  assign wr_data      = ELEM_WIDTH'($unsigned(cmd_ch.element));

  // ------------------------------------------------------------- sequencer
  // A new dot product starts only with a reserved output queue slot, so the
  // pipeline behind the memories never has to stall.
  assign issue      = (state == S_RUN) && ((k_cnt != '0) || (int'(credits) < FIFO_DEPTH));
  assign issue_last = (k_cnt == k_last) && (j_cnt == j_last) && (i_cnt == i_last);

  assign rd_addr_a = ADDR_W'(int'(i_cnt) * MAX_DIM + int'(k_cnt));
  assign rd_addr_b = ADDR_W'(int'(k_cnt) * MAX_DIM + int'(j_cnt));

  assign tag0.row       = i_cnt;
  assign tag0.col       = j_cnt;
  assign tag0.first     = (k_cnt == '0);
  assign tag0.last_k    = (k_cnt == k_last);
  assign tag0.last_elem = (j_cnt == j_last) && (i_cnt == i_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_beat && cmd_ch.command == CMD_START) begin
            state <= S_RUN;
            i_cnt <= '0;
            j_cnt <= '0;
            k_cnt <= '0;
          end
        end
        S_RUN: begin
          if (issue) begin
            if (k_cnt != k_last) begin
              k_cnt <= k_cnt + IDX_W'(1);
            end else begin
              k_cnt <= '0;
              if (j_cnt != j_last) begin
                j_cnt <= j_cnt + IDX_W'(1);
              end else begin
                j_cnt <= '0;
                if (i_cnt != i_last) begin
                  i_cnt <= i_cnt + IDX_W'(1);
                end else begin
                  i_cnt <= '0;
                  state <= S_IDLE;
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // -------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (load_ok && cmd_ch.command == CMD_LOAD_A) begin
      mem_a[wr_addr] <= wr_data;
    end
    a_rd <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (load_ok && cmd_ch.command == CMD_LOAD_B) begin
      mem_b[wr_addr] <= wr_data;
    end
    b_rd <= mem_b[rd_addr_b];
  end

  // -------------------------------------------------- multiply-accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      push3 <= 1'b0;
    end else begin
      v1    <= issue;
      v2    <= v1;
      push3 <= v2 && tag2.last_k;
    end
  end

  always_ff @(posedge clk) begin
    tag1 <= tag0;
    tag2 <= tag1;
    prod <= a_rd * b_rd;
    if (v2) begin
      tag3 <= tag2;
      acc  <= tag2.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // ---------------------------------------------------------- result queue
  assign pop  = res_ch.valid && res_ch.ready;
  assign head = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      credits  <= '0;
      fifo_cnt <= '0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
    end else begin
      credits  <= credits + FIFO_CNT_W'(issue && tag0.first) - FIFO_CNT_W'(pop);
      fifo_cnt <= fifo_cnt + FIFO_CNT_W'(push3) - FIFO_CNT_W'(pop);
      if (push3) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (pop)   rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push3) begin
      fifo_mem[wr_ptr].out_row     <= IDX_FIELD_W'(tag3.row);
      fifo_mem[wr_ptr].out_col     <= IDX_FIELD_W'(tag3.col);
      fifo_mem[wr_ptr].product_sum <= sat_sum(acc);
      fifo_mem[wr_ptr].last        <= tag3.last_elem;
    end
  end

  assign res_ch.valid       = (fifo_cnt != '0);
  assign res_ch.out_row     = head.out_row;
  assign res_ch.out_col     = head.out_col;
  assign res_ch.product_sum = head.product_sum;
  assign res_ch.last        = head.last;

  // ------------------------------------------------------------ assertions
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    int'(credits) <= FIFO_DEPTH)
    else $error("reserved queue slots exceed the queue depth");

  a_queue_reserved: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= credits)
    else $error("queued results exceed reserved slots");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push3 |-> (int'(fifo_cnt) < FIFO_DEPTH) || pop)
    else $error("result pushed into a full queue");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (issue && issue_last) |=> state == S_IDLE)
    else $error("sequencer did not return to idle after the final step");

  a_last_matches: assert property (@(posedge clk) disable iff (rst)
    (v2 && tag2.last_k && tag2.last_elem) |=> push3 && tag3.last_elem)
    else $error("final result of a run was not marked");

endmodule

[dv/mme_result_check.sv]
`timescale 1ns / 100ps
module mme_result_check import mme_pkg::*; (
  input  logic clk,
  input  logic rst,
  mme_cmd_if   cmd,
  mme_cfg_if   cfg,
  mme_res_if   res,
  output int   mismatches,
  output int   pending,
  output int   results_checked,
  output int   multiplies
);

  logic signed [ELEM_FIELD_W-1:0] a_elems [DEPTH];
  logic signed [ELEM_FIELD_W-1:0] b_elems [DEPTH];
  logic [DIM_REG_W-1:0] rows_reg;
  logic [DIM_REG_W-1:0] inner_reg;
  logic [DIM_REG_W-1:0] cols_reg;
  result_t product_queue [$];

  // A register value of zero acts as one, anything past MAX_DIM as MAX_DIM.
  function automatic int span(input logic [DIM_REG_W-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  function automatic logic signed [SUM_W-1:0] clamp_sum(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SUM_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[SUM_W-1:0];
  endfunction

  task automatic queue_products();
    int nr;
    int nk;
    int nc;
    longint acc;
    result_t r;
    nr = span(rows_reg);
    nk = span(inner_reg);
    nc = span(cols_reg);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          acc += longint'(a_elems[i*MAX_DIM + k]) * longint'(b_elems[k*MAX_DIM + j]);
        end
        r.out_row     = IDX_FIELD_W'(i);
        r.out_col     = IDX_FIELD_W'(j);
        r.product_sum = clamp_sum(acc);
        r.last        = (i == nr - 1) && (j == nc - 1);
        product_queue.push_back(r);
      end
    end
  endtask

  task automatic report(input string what, input result_t want, input result_t got);
    if (mismatches < 10) begin
      $display("%0t: %s: expected row %0d col %0d sum %0d last %0b,",
               $realtime, what, want.out_row, want.out_col, $signed(want.product_sum),
               want.last);
      $display("    got row %0d col %0d sum %0d last %0b",
               got.out_row, got.out_col, $signed(got.product_sum), got.last);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      rows_reg  = DIM_REG_W'(MAX_DIM);
      inner_reg = DIM_REG_W'(MAX_DIM);
      cols_reg  = DIM_REG_W'(MAX_DIM);
      product_queue.delete();
      mismatches = 0;
      results_checked = 0;
      multiplies = 0;
      foreach (a_elems[n]) begin
        a_elems[n] = '0;
        b_elems[n] = '0;
      end
    end else begin
      if (res.valid && res.ready) begin
        got.out_row     = res.out_row;
        got.out_col     = res.out_col;
        got.product_sum = res.product_sum;
        got.last        = res.last;
        if (product_queue.size() == 0) begin
          want = '0;
          report("result beat with nothing expected", want, got);
        end else begin
          want = product_queue.pop_front();
          if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
              got.product_sum !== want.product_sum || got.last !== want.last) begin
            report("result mismatch", want, got);
          end
        end
        results_checked++;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_ROWS_A:    rows_reg = cfg.data;
          REG_INNER_DIM: inner_reg = cfg.data;
          REG_COLS_B:    cols_reg = cfg.data;
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        case (cmd_t'(cmd.command))
          CMD_LOAD_A: a_elems[int'(cmd.row_index)*MAX_DIM + int'(cmd.col_index)] = cmd.element;
          CMD_LOAD_B: b_elems[int'(cmd.row_index)*MAX_DIM + int'(cmd.col_index)] = cmd.element;
          CMD_START: begin
            queue_products();
            multiplies++;
          end
          default: ;
        endcase
      end
    end
    pending = product_queue.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
module testbench;
  import mme_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  mme_cmd_if cmd_ch ();
  mme_cfg_if cfg_ch ();
  mme_res_if res_ch ();

  matrix_multiply_engine DUT (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .cfg_ch (cfg_ch),
    .res_ch (res_ch)
  );

  int mismatches;
  int pending;
  int results_checked;
  int multiplies;

  mme_result_check result_check (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd_ch),
    .cfg             (cfg_ch),
    .res             (res_ch),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .multiplies      (multiplies)
  );

  bit a_loaded [DEPTH];
  bit b_loaded [DEPTH];
  int rows_n = MAX_DIM;
  int inner_n = MAX_DIM;
  int cols_n = MAX_DIM;
  int cmd_items = 0;
  int reg_writes = 0;
  bit steady = 1'b0;
  int stall_left = 0;
  int calm_left = 0;
  int quiet_cycles = 0;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int eff_dim(input logic [DIM_REG_W-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  function automatic logic [DIM_REG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return DIM_REG_W'(MAX_DIM);
    if (r < 22) return DIM_REG_W'($urandom_range(MAX_DIM + 1, 15));
    if (r < 30) return DIM_REG_W'(1);
    return DIM_REG_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [ELEM_FIELD_W-1:0] pick_element();
    case ($urandom_range(0, 19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return ELEM_FIELD_W'($urandom);
    endcase
  endfunction

  // Receiver: mostly ready, with stalls of random length and occasional calm stretches.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if (calm_left != 0) begin
        calm_left = calm_left - 1;
      end else if ($urandom_range(0, 99) < 30) begin
        stall_left = idle_len();
      end else if ($urandom_range(0, 199) == 0) begin
        calm_left = 150;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("No beat on any channel for %0d cycles, %0d results outstanding.",
               WATCHDOG_LIMIT, pending);
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves valid high after the beat; the caller lowers it when the stream pauses.
  task automatic send_cmd(input logic [CMD_W-1:0] code, input int row, input int col,
                          input logic [ELEM_FIELD_W-1:0] value);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.command   <= code;
    cmd_ch.row_index <= IDX_FIELD_W'(row);
    cmd_ch.col_index <= IDX_FIELD_W'(col);
    cmd_ch.element   <= value;
    do @(posedge clk); while (!cmd_ch.ready);
    cmd_items++;
    if (code == CMD_LOAD_A) a_loaded[row*MAX_DIM + col] = 1'b1;
    else if (code == CMD_LOAD_B) b_loaded[row*MAX_DIM + col] = 1'b1;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_REG_W-1:0] value);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      cfg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    reg_writes++;
    case (idx)
      REG_ROWS_A:    rows_n = eff_dim(value);
      REG_INNER_DIM: inner_n = eff_dim(value);
      REG_COLS_B:    cols_n = eff_dim(value);
      default: ;
    endcase
  endtask

  // Stop the command stream, let every expected result drain, then idle
  // before returning so any trailing load can finish.
  task automatic quiesce();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic new_setting();
    if ($urandom_range(0, 9) < 7) write_reg(REG_ROWS_A, pick_dim());
    if ($urandom_range(0, 9) < 7) write_reg(REG_INNER_DIM, pick_dim());
    if ($urandom_range(0, 9) < 7) write_reg(REG_COLS_B, pick_dim());
    cfg_ch.valid <= 1'b0;
  endtask

  // Loads every element the next product reads that is still unwritten, reloads
  // a random part or all of the rest, sprinkles in stray commands and then starts.
  task automatic multiply_run();
    int order [2*DEPTH];
    int n;
    int t;
    int s;
    int slot;
    bit for_b;
    bit refill;
    logic [ELEM_FIELD_W-1:0] fill_a;
    logic [ELEM_FIELD_W-1:0] fill_b;
    logic [CMD_W-1:0] code;
    refill = ($urandom_range(0, 11) == 0);
    fill_a = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    fill_b = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    n = 0;
    for (int i = 0; i < rows_n; i++) begin
      for (int k = 0; k < inner_n; k++) begin
        order[n] = i*MAX_DIM + k;
        n++;
      end
    end
    for (int k = 0; k < inner_n; k++) begin
      for (int j = 0; j < cols_n; j++) begin
        order[n] = DEPTH + k*MAX_DIM + j;
        n++;
      end
    end
    for (t = n - 1; t > 0; t--) begin
      s = $urandom_range(0, t);
      slot = order[t];
      order[t] = order[s];
      order[s] = slot;
    end
    for (t = 0; t < n; t++) begin
      for_b = order[t] >= DEPTH;
      slot = order[t] % DEPTH;
      if (refill || !(for_b ? b_loaded[slot] : a_loaded[slot]) || $urandom_range(0, 3) == 0) begin
        if (for_b) begin
          send_cmd(CMD_LOAD_B, slot / MAX_DIM, slot % MAX_DIM, refill ? fill_b : pick_element());
        end else begin
          send_cmd(CMD_LOAD_A, slot / MAX_DIM, slot % MAX_DIM, refill ? fill_a : pick_element());
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: code = CMD_UNUSED;
          1: code = CMD_LOAD_A;
          default: code = CMD_LOAD_B;
        endcase
        send_cmd(code, $urandom_range(0, 7), $urandom_range(0, 7), ELEM_FIELD_W'($urandom));
      end
    end
    send_cmd(CMD_START, $urandom_range(0, 7), $urandom_range(0, 7), ELEM_FIELD_W'($urandom));
  endtask

  initial begin
    cmd_ch.valid     = 1'b0;
    cmd_ch.command   = CMD_LOAD_A;
    cmd_ch.row_index = '0;
    cmd_ch.col_index = '0;
    cmd_ch.element   = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_ROWS_A;
    cfg_ch.data      = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Single-element products at the extremes of the element range.
    write_reg(REG_ROWS_A, DIM_REG_W'(1));
    write_reg(REG_INNER_DIM, DIM_REG_W'(1));
    write_reg(REG_COLS_B, DIM_REG_W'(1));
    cfg_ch.valid <= 1'b0;
    send_cmd(CMD_LOAD_A, 0, 0, 16'h8000);
    send_cmd(CMD_LOAD_B, 0, 0, 16'h8000);
    send_cmd(CMD_START, 7, 7, 16'hFFFF);
    send_cmd(CMD_LOAD_A, 0, 0, 16'h7FFF);
    send_cmd(CMD_UNUSED, 7, 7, 16'hFFFF);
    send_cmd(CMD_LOAD_B, 7, 7, 16'h0001);
    send_cmd(CMD_START, 0, 0, 16'h0000);
    quiesce();

    // A zero row count acts as one row.
    write_reg(REG_ROWS_A, '0);
    write_reg(REG_INNER_DIM, DIM_REG_W'(2));
    write_reg(REG_COLS_B, DIM_REG_W'(2));
    cfg_ch.valid <= 1'b0;
    send_cmd(CMD_LOAD_A, 0, 1, 16'h7FFF);
    send_cmd(CMD_LOAD_B, 1, 0, 16'h8000);
    send_cmd(CMD_LOAD_B, 0, 1, 16'h0001);
    send_cmd(CMD_LOAD_B, 1, 1, 16'hFFFF);
    send_cmd(CMD_START, 3, 5, 16'h1234);
    quiesce();

    // A column count past the maximum acts as the maximum.
    write_reg(REG_INNER_DIM, DIM_REG_W'(1));
    write_reg(REG_COLS_B, 4'hF);
    cfg_ch.valid <= 1'b0;
    for (int j = 2; j < MAX_DIM; j++) send_cmd(CMD_LOAD_B, 0, j, pick_element());
    send_cmd(CMD_START, 0, 0, 16'h0000);

    while (cmd_items < 520) begin
      quiesce();
      steady = ($urandom_range(0, 3) == 0);
      new_setting();
      repeat ($urandom_range(1, 3)) multiply_run();
    end

    quiesce();
    repeat (20) @(posedge clk);
    $display("Sent %0d commands including %0d multiplies, with %0d register writes.",
             cmd_items, multiplies, reg_writes);
    $display("Checked %0d result elements, %0d mismatches, %0d still expected.",
             results_checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mme_pkg.sv
hdl/mme_cmd_if.sv
hdl/mme_res_if.sv
hdl/mme_cfg_if.sv
hdl/matrix_multiply_engine.sv
dv/mme_result_check.sv
dv/testbench.sv
